FILE: sv/rrs_pkg.sv
// Shared constants and types for the rounded rectangle row span block.
package rrs_pkg;

   localparam int COORD_BITS_DEF = 13;
   localparam int CSR_IDX_BITS   = 3;

   localparam logic [CSR_IDX_BITS-1:0] REG_RECT_X        = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_RECT_Y        = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_RECT_WIDTH    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_RECT_HEIGHT   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_CORNER_RADIUS = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd6;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_BOUND  = 9'b000000010,
      S_CORNER = 9'b000000100,
      S_SQR    = 9'b000001000,
      S_SQD    = 9'b000010000,
      S_NEED   = 9'b000100000,
      S_TRY    = 9'b001000000,
      S_CHK    = 9'b010000000,
      S_FIN    = 9'b100000000
   } state_type;

endpackage

FILE: sv/rrs_csr_regs.sv
// Configuration register file for the rounded rectangle row span block.
module rrs_csr_regs #(
   parameter int COORD_BITS = rrs_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [rrs_pkg::CSR_IDX_BITS-1:0]  wr_index,
   input  logic [COORD_BITS:0]               wr_data,
   output logic signed [COORD_BITS:0]        rect_x_ff,
   output logic signed [COORD_BITS:0]        rect_y_ff,
   output logic signed [COORD_BITS:0]        rect_w_ff,
   output logic signed [COORD_BITS:0]        rect_h_ff,
   output logic [COORD_BITS-2:0]             radius_ff,
   output logic [COORD_BITS-1:0]             screen_w_ff,
   output logic [COORD_BITS-1:0]             screen_h_ff
);

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_x_ff   <= '0;
         rect_y_ff   <= '0;
         rect_w_ff   <= '0;
         rect_h_ff   <= '0;
         radius_ff   <= '0;
         screen_w_ff <= '0;
         screen_h_ff <= '0;
      end else if (wr_en) begin
         case (wr_index)
            rrs_pkg::REG_RECT_X:        rect_x_ff   <= wr_data;
            rrs_pkg::REG_RECT_Y:        rect_y_ff   <= wr_data;
            rrs_pkg::REG_RECT_WIDTH:    rect_w_ff   <= wr_data;
            rrs_pkg::REG_RECT_HEIGHT:   rect_h_ff   <= wr_data;
            rrs_pkg::REG_CORNER_RADIUS: radius_ff   <= wr_data[COORD_BITS-2:0];
            rrs_pkg::REG_SCREEN_WIDTH:  screen_w_ff <= wr_data[COORD_BITS-1:0];
            rrs_pkg::REG_SCREEN_HEIGHT: screen_h_ff <= wr_data[COORD_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

FILE: sv/rrs_mul_unit.sv
// Shared unsigned multiplier with registered product.
module rrs_mul_unit #(
   parameter int W = rrs_pkg::COORD_BITS_DEF - 1
) (
   input  logic             clock,
   input  logic [W-1:0]     op_a,
   input  logic [W-1:0]     op_b,
   output logic [2*W-1:0]   prod_ff
);

   logic [2*W-1:0] prod_in;

   assign prod_in = (2*W)'(op_a) * (2*W)'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: sv/rounded_rect_row_span_core.sv
// Top level: rounded rectangle row span generator with shared multiplier sequencer.
//
// Usage:
//   Program the rectangle, corner radius and screen size through the csr_
//   write channel (index = register number) while the block is idle; csr_ready
//   is always high. Each req_ transfer names one screen row; one rsp_ transfer
//   returns draw_row, span_left and span_width for that row.
//   A req_ transfer leads through the bound and corner steps; rows that need no
//   corner inset then go straight to the final step, while corner rows first
//   square the radius and the row offset, form the needed value and then
//   search the root. The corner inset comes from a bit-serial square root
//   search, one result bit per try and compare step pair, through the single
//   shared multiplier. req_stall is high while a row is in work, so one row
//   is in flight at a time; the next row is taken while a result still waits.
//   When rsp_stall holds the result register, a finished row waits in its
//   last step until the register frees.
//   Synchronous reset clears the configuration registers to zero, returns the
//   sequencer to idle and empties the result register.
module rounded_rect_row_span_core #(
   parameter int COORD_BITS = rrs_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [COORD_BITS-1:0]             req_row,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_draw_row,
   output logic [COORD_BITS-1:0]             rsp_span_left,
   output logic [COORD_BITS-1:0]             rsp_span_width,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [rrs_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [COORD_BITS:0]               csr_wdata
);

   localparam int CB = COORD_BITS;
   localparam int PB = COORD_BITS + 1;
   localparam int RB = COORD_BITS - 1;
   localparam int EW = COORD_BITS + 3;
   localparam int MW = 2 * RB;

   logic signed [PB-1:0] rect_x, rect_y, rect_w, rect_h;
   logic [RB-1:0]        radius;
   logic [CB-1:0]        screen_w, screen_h;

   rrs_pkg::state_type state_ff, state_in;

   logic [CB-1:0]        row_ff;
   logic                 nodraw_ff, corner_ff;
   logic signed [EW-1:0] sx_ff, sy_ff, exc_ff, eyc_ff, ly_ff;
   logic [RB-1:0]        r_ff, dy_ff, acc_ff, bit_ff;
   logic [MW-1:0]        rr_ff, need_ff;
   logic                 out_valid_ff, out_draw_ff;
   logic [CB-1:0]        out_left_ff, out_width_ff;

   logic [RB-1:0]        mul_a;
   logic [MW-1:0]        prod;

   logic signed [EW-1:0] x_e, y_e, w_e, h_e, sw_e, sh_e, py_e, rq_e, r_e;
   logic signed [EW-1:0] ex, ey, minwh, maxr, ly, hmr, dy_top, dy_bot;
   logic signed [EW-1:0] inset_e, left, right, lc, rc, span;
   logic                 empty, offscr, rowout, top, bot, draw, out_load;
   logic [RB-1:0]        trial, inset;

   assign csr_ready = 1'b1;

   rrs_csr_regs #(.COORD_BITS(COORD_BITS)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (csr_valid & csr_ready),
      .wr_index    (csr_index),
      .wr_data     (csr_wdata),
      .rect_x_ff   (rect_x),
      .rect_y_ff   (rect_y),
      .rect_w_ff   (rect_w),
      .rect_h_ff   (rect_h),
      .radius_ff   (radius),
      .screen_w_ff (screen_w),
      .screen_h_ff (screen_h)
   );

   rrs_mul_unit #(.W(RB)) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_a),
      .prod_ff (prod)
   );

   assign x_e  = {{(EW-PB){rect_x[PB-1]}}, rect_x};
   assign y_e  = {{(EW-PB){rect_y[PB-1]}}, rect_y};
   assign w_e  = {{(EW-PB){rect_w[PB-1]}}, rect_w};
   assign h_e  = {{(EW-PB){rect_h[PB-1]}}, rect_h};
   assign sw_e = {{(EW-CB){1'b0}}, screen_w};
   assign sh_e = {{(EW-CB){1'b0}}, screen_h};
   assign py_e = {{(EW-CB){1'b0}}, row_ff};
   assign rq_e = {{(EW-RB){1'b0}}, radius};
   assign r_e  = {{(EW-RB){1'b0}}, r_ff};

   // bounds and radius clamp
   assign ex     = x_e + w_e;
   assign ey     = y_e + h_e;
   assign empty  = w_e[EW-1] || (w_e == '0) || h_e[EW-1] || (h_e == '0);
   assign offscr = (x_e >= sw_e) || (y_e >= sh_e) || (ex <= 0) || (ey <= 0);
   assign minwh  = (w_e < h_e) ? w_e : h_e;
   assign maxr   = minwh >>> 1;
   assign ly     = py_e - y_e;

   // corner classification
   assign rowout = (py_e < sy_ff) || (py_e >= eyc_ff);
   assign hmr    = h_e - r_e;
   assign top    = (r_ff != '0) && (ly_ff < r_e);
   assign bot    = (r_ff != '0) && !top && (ly_ff >= hmr);
   assign dy_top = r_e - ly_ff - EW'(1);
   assign dy_bot = ly_ff - hmr;

   assign trial = acc_ff | bit_ff;

   always_comb begin
      case (state_ff)
         rrs_pkg::S_SQR: mul_a = r_ff;
         rrs_pkg::S_SQD: mul_a = dy_ff;
         rrs_pkg::S_TRY: mul_a = trial;
         default:        mul_a = '0;
      endcase
   end

   // final span
   assign inset   = corner_ff ? (r_ff - acc_ff - RB'(1)) : '0;
   assign inset_e = {{(EW-RB){1'b0}}, inset};
   assign left    = x_e + inset_e;
   assign right   = ex - inset_e;
   assign lc      = (left < sx_ff) ? sx_ff : left;
   assign rc      = (right > exc_ff) ? exc_ff : right;
   assign span    = rc - lc;
   assign draw    = !nodraw_ff && !span[EW-1] && (span != '0);
   assign out_load = (state_ff == rrs_pkg::S_FIN) && (!out_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrs_pkg::S_IDLE:   if (req_valid) state_in = rrs_pkg::S_BOUND;
         rrs_pkg::S_BOUND:  state_in = rrs_pkg::S_CORNER;
         rrs_pkg::S_CORNER: state_in = ((top || bot) && !nodraw_ff && !rowout) ?
                                       rrs_pkg::S_SQR : rrs_pkg::S_FIN;
         rrs_pkg::S_SQR:    state_in = rrs_pkg::S_SQD;
         rrs_pkg::S_SQD:    state_in = rrs_pkg::S_NEED;
         rrs_pkg::S_NEED:   state_in = rrs_pkg::S_TRY;
         rrs_pkg::S_TRY:    state_in = rrs_pkg::S_CHK;
         rrs_pkg::S_CHK:    state_in = bit_ff[0] ? rrs_pkg::S_FIN : rrs_pkg::S_TRY;
         rrs_pkg::S_FIN:    if (out_load) state_in = rrs_pkg::S_IDLE;
         default:           state_in = rrs_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrs_pkg::S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         rrs_pkg::S_IDLE: begin
            if (req_valid) row_ff <= req_row;
         end
         rrs_pkg::S_BOUND: begin
            nodraw_ff <= empty || offscr;
            sx_ff     <= x_e[EW-1] ? '0 : x_e;
            sy_ff     <= y_e[EW-1] ? '0 : y_e;
            exc_ff    <= (ex > sw_e) ? sw_e : ex;
            eyc_ff    <= (ey > sh_e) ? sh_e : ey;
            r_ff      <= (rq_e > maxr) ? maxr[RB-1:0] : radius;
            ly_ff     <= ly;
         end
         rrs_pkg::S_CORNER: begin
            nodraw_ff <= nodraw_ff || rowout;
            corner_ff <= top || bot;
            dy_ff     <= top ? dy_top[RB-1:0] : dy_bot[RB-1:0];
         end
         rrs_pkg::S_SQD: begin
            rr_ff <= prod;
         end
         rrs_pkg::S_NEED: begin
            need_ff <= rr_ff - prod;
            acc_ff  <= '0;
            bit_ff  <= {1'b1, {(RB-1){1'b0}}};
         end
         rrs_pkg::S_CHK: begin
            if (prod < need_ff) acc_ff <= trial;
            bit_ff <= bit_ff >> 1;
         end
         default: begin
         end
      endcase
      if (out_load) begin
         out_draw_ff  <= draw;
         out_left_ff  <= draw ? lc[CB-1:0] : '0;
         out_width_ff <= draw ? span[CB-1:0] : '0;
      end
   end

   assign req_stall      = (state_ff != rrs_pkg::S_IDLE);
   assign rsp_valid      = out_valid_ff;
   assign rsp_draw_row   = out_draw_ff;
   assign rsp_span_left  = out_left_ff;
   assign rsp_span_width = out_width_ff;

   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == rrs_pkg::S_BOUND))
      else $error("accepted row did not start the sequence");

   a_chk_after_try : assert property (@(posedge clock) disable iff (reset)
      (state_ff == rrs_pkg::S_CHK) |-> ($past(state_ff) == rrs_pkg::S_TRY))
      else $error("compare step without a multiply step");

   a_root_below_r : assert property (@(posedge clock) disable iff (reset)
      (state_ff == rrs_pkg::S_FIN && corner_ff && !nodraw_ff) |-> (acc_ff < r_ff))
      else $error("root search exceeded radius");

   a_draw_width : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_draw_row) |-> (rsp_span_width != '0))
      else $error("drawn row with empty span");

   a_nodraw_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_draw_row) |-> (rsp_span_width == '0 && rsp_span_left == '0))
      else $error("undrawn row with nonzero fields");

endmodule
